>>> sv/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and byte codes for the remote command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

  // Frame delimiters and flag byte masks
  localparam logic [7:0] FRAME_START  = 8'hA5;
  localparam logic [7:0] FRAME_END    = 8'h5A;
  localparam logic [7:0] MASK_KEYS    = 8'h0F;
  localparam logic [7:0] BIT_SUCK_OFF = 8'h20;
  localparam logic [7:0] BIT_SUCK_ON  = 8'h10;
  localparam logic [7:0] BIT_VALVE    = 8'h40;

  localparam int unsigned PAYLOAD_LEN = 5;

  // Button codes (ASCII)
  localparam logic [7:0] KEY_A_SET   = 8'h41;  // 'A'
  localparam logic [7:0] KEY_A_CLR   = 8'h61;  // 'a'
  localparam logic [7:0] KEY_B_SET   = 8'h42;  // 'B'
  localparam logic [7:0] KEY_B_CLR   = 8'h62;  // 'b'
  localparam logic [7:0] KEY_C_SET   = 8'h43;  // 'C'
  localparam logic [7:0] KEY_C_CLR   = 8'h63;  // 'c'
  localparam logic [7:0] KEY_D_SET   = 8'h44;  // 'D'
  localparam logic [7:0] KEY_D_CLR   = 8'h64;  // 'd'
  localparam logic [7:0] SUCK_ON     = 8'h45;  // 'E'
  localparam logic [7:0] SUCK_OFF    = 8'h46;  // 'F'
  localparam logic [7:0] VALVE_SET   = 8'h47;  // 'G'
  localparam logic [7:0] VALVE_CLR   = 8'h67;  // 'g'
  localparam logic [7:0] STOP_ALL    = 8'h58;  // 'X'

  // Request kind carried on in_tuser
  localparam logic CMD_BYTE       = 1'b0;
  localparam logic CMD_LINE_ERROR = 1'b1;

  localparam int unsigned OUT_DATA_W = 32;

  // One result, packed MSB first so keys sit in the low bits
  typedef struct packed {
    logic             control_refresh;
    logic signed [7:0] vel_turn;
    logic signed [7:0] vel_y;
    logic signed [7:0] vel_x;
    logic             valve_state;
    logic             suction_state;
    logic [3:0]       motor_keys;
  } rcfp_result_t;

endpackage : rcfp_pkg

`default_nettype wire

>>> sv/rcfp_core.sv
// ----------------------------------------------------------------------------
// rcfp_core
// Parser state, payload store and held control state. Produces the result
// for the request presented this cycle and commits the new state on accept.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  cmd,
  input  wire logic [7:0]            rx_byte,
  output rcfp_pkg::rcfp_result_t     result
);
  import rcfp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_END     = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [7:0]  store_r [PAYLOAD_LEN];
  logic [3:0]  keys_r, keys_nxt;
  logic        suck_r, suck_nxt;
  logic        valve_r, valve_nxt;
  logic [7:0]  sx_r, sx_nxt;
  logic [7:0]  sy_r, sy_nxt;
  logic [7:0]  st_r, st_nxt;
  logic        refresh;
  logic        store_we;
  logic [2:0]  store_idx;
  logic [2:0]  count_inc;
  logic [7:0]  sum;

  // Store index wraps within five entries
  assign store_idx = (count_r >= 3'(PAYLOAD_LEN)) ? count_r - 3'(PAYLOAD_LEN) : count_r;
  assign count_inc = count_r + 3'd1;
  assign sum       = store_r[0] + store_r[1] + store_r[2] + store_r[3];

  // Next state for the current request
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    keys_nxt  = keys_r;
    suck_nxt  = suck_r;
    valve_nxt = valve_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    st_nxt    = st_r;
    refresh   = 1'b0;
    store_we  = 1'b0;

    if (cmd == CMD_LINE_ERROR) begin
      phase_nxt = PH_IDLE;
      count_nxt = 3'd0;
      valve_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte == FRAME_START) begin
            count_nxt = 3'd0;
            phase_nxt = PH_COLLECT;
          end else begin
            // Button decode
            refresh = 1'b1;
            unique case (rx_byte)
              KEY_A_SET: keys_nxt = keys_r | 4'b0001;
              KEY_A_CLR: keys_nxt = keys_r & 4'b1110;
              KEY_B_SET: keys_nxt = keys_r | 4'b0010;
              KEY_B_CLR: keys_nxt = keys_r & 4'b1101;
              KEY_C_SET: keys_nxt = keys_r | 4'b0100;
              KEY_C_CLR: keys_nxt = keys_r & 4'b1011;
              KEY_D_SET: keys_nxt = keys_r | 4'b1000;
              KEY_D_CLR: keys_nxt = keys_r & 4'b0111;
              SUCK_ON: begin
                suck_nxt = 1'b1;
                refresh  = 1'b0;
              end
              SUCK_OFF: begin
                suck_nxt = 1'b0;
                refresh  = 1'b0;
              end
              VALVE_SET: valve_nxt = 1'b1;
              VALVE_CLR: valve_nxt = 1'b0;
              STOP_ALL: begin
                sx_nxt    = 8'd0;
                sy_nxt    = 8'd0;
                st_nxt    = 8'd0;
                keys_nxt  = 4'd0;
                valve_nxt = 1'b0;
              end
              default: refresh = 1'b0;
            endcase
          end
        end
        PH_COLLECT: begin
          store_we  = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= 3'(PAYLOAD_LEN)) phase_nxt = PH_END;
        end
        PH_END: begin
          // End byte and checksum both have to match
          if (rx_byte == FRAME_END && sum == store_r[4]) begin
            keys_nxt = store_r[0][3:0] & MASK_KEYS[3:0];
            if ((store_r[0] & BIT_SUCK_OFF) != 8'd0)     suck_nxt = 1'b0;
            else if ((store_r[0] & BIT_SUCK_ON) != 8'd0) suck_nxt = 1'b1;
            valve_nxt = (store_r[0] & BIT_VALVE) != 8'd0;
            sx_nxt    = store_r[1];
            sy_nxt    = store_r[2];
            st_nxt    = store_r[3];
            refresh   = 1'b1;
          end
          phase_nxt = PH_IDLE;
          count_nxt = 3'd0;
        end
        default: begin
          phase_nxt = PH_IDLE;
          count_nxt = 3'd0;
        end
      endcase
    end
  end

  // Control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= 3'd0;
      keys_r  <= 4'd0;
      suck_r  <= 1'b0;
      valve_r <= 1'b0;
      sx_r    <= 8'd0;
      sy_r    <= 8'd0;
      st_r    <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      keys_r  <= keys_nxt;
      suck_r  <= suck_nxt;
      valve_r <= valve_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      st_r    <= st_nxt;
    end
  end

  // Payload store, no reset
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      store_r[store_idx] <= rx_byte;
    end
  end

  assign result.motor_keys      = keys_nxt;
  assign result.suction_state   = suck_nxt;
  assign result.valve_state     = valve_nxt;
  assign result.vel_x           = sx_nxt;
  assign result.vel_y           = sy_nxt;
  assign result.vel_turn        = st_nxt;
  assign result.control_refresh = refresh;

endmodule : rcfp_core

`default_nettype wire

>>> sv/remote_command_frame_parser.sv
// ----------------------------------------------------------------------------
// remote_command_frame_parser
// Remote-control link command parser with framed joystick packets.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per received byte (in_tuser = 0, byte on
//   in_tdata) or per line-error event (in_tuser = 1, in_tdata ignored).
//   Output stream: exactly one result per request, carrying the held key,
//   suction, valve and joystick state after that request plus a refresh flag.
//   Registering: each result is registered, in the skid register if the output one is stalled.
//   Throughput: one request per cycle while in_tready is high; parser state
//   is updated in the accept cycle, so back-to-back requests need no gap.
//   Stall: an output register plus a one-entry skid register absorb a stalled
//   receiver; in_tready drops only once the skid register is full, and
//   results keep their order.
//   Reset: synchronous, active low; parser idle, held state zero, both
//   output registers empty. The payload store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_command_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [3:0] motor_keys, [4] suction_state,
                                       // [5] valve_state, [13:6] vel_x,
                                       // [21:14] vel_y, [29:22] vel_turn,
                                       // [30] control_refresh, [31] zero
);
  import rcfp_pkg::*;

  rcfp_result_t res;
  rcfp_result_t out_r, skid_r;
  logic         out_valid_r, skid_valid_r;
  logic         in_acc, out_acc;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  rcfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .cmd     (in_tuser[0]),
    .rx_byte (in_tdata),
    .result  (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_acc) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_valid_r || out_acc) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(rcfp_result_t)){1'b0}}, out_r};

endmodule : remote_command_frame_parser

`default_nettype wire

>>> sv/rcfp_checker.sv
// ----------------------------------------------------------------------------
// rcfp_checker
// Port-level checks for the remote command frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // Output is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Backpressure only when a result is already waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // Line error drops the valve and gives no refresh, result next cycle
  a_line_error: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] && (!out_tvalid || out_tready))
    |=> (out_tvalid && !out_tdata[5] && !out_tdata[30]))
    else $error("line error result wrong");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule : rcfp_checker

bind remote_command_frame_parser rcfp_checker u_rcfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> tb/remote_command_frame_parser_test.sv
// ----------------------------------------------------------------------------
// remote_command_frame_parser_test
// Stream-level test of the remote command frame parser: directed button,
// frame and line-error requests, then random traffic built mostly from
// well-formed frames, checked result by result against a behavioural copy
// of the parser's held state under varying back-pressure.
// ----------------------------------------------------------------------------
module remote_command_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE, PH_PAYLOAD, PH_END, PH_UNUSED
  } parse_phase_t;

  typedef enum logic [1:0] {
    MODE_RX_SLOW, MODE_TX_SLOW, MODE_NO_IDLE
  } idle_mode_t;

  localparam logic [7:0] BUTTON_CODES [0:12] = '{
    KEY_A_SET, KEY_A_CLR, KEY_B_SET, KEY_B_CLR, KEY_C_SET, KEY_C_CLR,
    KEY_D_SET, KEY_D_CLR, SUCK_ON, SUCK_OFF, VALVE_SET, VALVE_CLR, STOP_ALL
  };

  // Held-state tracker: mirrors the parser and queues the expected results
  class held_state_board;
    parse_phase_t phase;
    logic [2:0]   count;
    logic [7:0]   payload [PAYLOAD_LEN];
    logic [3:0]   keys;
    logic         suction;
    logic         valve;
    logic [7:0]   stick_x, stick_y, stick_turn;
    rcfp_result_t expected_states [$];
    int           errors, requests, refreshes, line_errors, frames_taken;

    function new();
      phase = PH_IDLE;
      count = '0;
      foreach (payload[i]) payload[i] = '0;
      keys = '0;
      suction = 1'b0;
      valve = 1'b0;
      stick_x = '0;
      stick_y = '0;
      stick_turn = '0;
    endfunction

    // Button press outside a frame; returns 1 for a key, valve or stop-all command
    function logic press_button(logic [7:0] b);
      case (b)
        KEY_A_SET: keys = keys | 4'b0001;
        KEY_A_CLR: keys = keys & 4'b1110;
        KEY_B_SET: keys = keys | 4'b0010;
        KEY_B_CLR: keys = keys & 4'b1101;
        KEY_C_SET: keys = keys | 4'b0100;
        KEY_C_CLR: keys = keys & 4'b1011;
        KEY_D_SET: keys = keys | 4'b1000;
        KEY_D_CLR: keys = keys & 4'b0111;
        SUCK_ON: begin
          suction = 1'b1;
          return 1'b0;
        end
        SUCK_OFF: begin
          suction = 1'b0;
          return 1'b0;
        end
        VALVE_SET: valve = 1'b1;
        VALVE_CLR: valve = 1'b0;
        STOP_ALL: begin
          keys = '0;
          valve = 1'b0;
          stick_x = '0;
          stick_y = '0;
          stick_turn = '0;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_request(logic cmd, logic [7:0] b);
      rcfp_result_t want;
      logic         refresh;
      logic [7:0]   sum;
      refresh = 1'b0;
      requests++;
      if (cmd == CMD_LINE_ERROR) begin
        line_errors++;
        phase = PH_IDLE;
        count = '0;
        valve = 1'b0;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (b == FRAME_START) begin
              count = '0;
              phase = PH_PAYLOAD;
            end else begin
              refresh = press_button(b);
            end
          end
          PH_PAYLOAD: begin
            payload[int'(count) % PAYLOAD_LEN] = b;
            count = count + 3'd1;
            if (count >= PAYLOAD_LEN) phase = PH_END;
          end
          PH_END: begin
            sum = payload[0] + payload[1] + payload[2] + payload[3];
            if (b == FRAME_END && sum == payload[4]) begin
              keys = payload[0][3:0] & MASK_KEYS[3:0];
              // suction off wins over on; neither keeps the latch
              if ((payload[0] & BIT_SUCK_OFF) != 0) suction = 1'b0;
              else if ((payload[0] & BIT_SUCK_ON) != 0) suction = 1'b1;
              valve = ((payload[0] & BIT_VALVE) != 0);
              stick_x = payload[1];
              stick_y = payload[2];
              stick_turn = payload[3];
              refresh = 1'b1;
              frames_taken++;
            end
            phase = PH_IDLE;
            count = '0;
          end
          default: begin
            phase = PH_IDLE;
            count = '0;
          end
        endcase
      end
      if (refresh) refreshes++;
      want.motor_keys = keys;
      want.suction_state = suction;
      want.valve_state = valve;
      want.vel_x = stick_x;
      want.vel_y = stick_y;
      want.vel_turn = stick_turn;
      want.control_refresh = refresh;
      expected_states.push_back(want);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [31:0] data);
      rcfp_result_t want, got;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = expected_states.pop_front();
      got = data[30:0];
      compare_field("motor_keys", want.motor_keys, got.motor_keys);
      compare_field("suction_state", want.suction_state, got.suction_state);
      compare_field("valve_state", want.valve_state, got.valve_state);
      compare_field("vel_x", want.vel_x, got.vel_x);
      compare_field("vel_y", want.vel_y, got.vel_y);
      compare_field("vel_turn", want.vel_turn, got.vel_turn);
      compare_field("control_refresh", want.control_refresh, got.control_refresh);
      compare_field("spare bit", 0, data[31]);
    endfunction

    function int outstanding();
      return expected_states.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [0:0]  in_tuser = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [3:0] keys, [4] suction, [5] valve, [13:6] vel_x,
                                // [21:14] vel_y, [29:22] vel_turn, [30] refresh

  held_state_board board = new();
  idle_mode_t      idle_mode = MODE_RX_SLOW;
  int              send_idle_pct = 35;
  int              n_sent = 0;
  int              stall_left = 0;
  bit              stall_done = 1'b0;

  remote_command_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // Receiver: random idling per mode, plus one long hold-off when idling stops
  always @(posedge clk) begin
    if (idle_mode == MODE_NO_IDLE && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (idle_mode)
        MODE_RX_SLOW: out_tready <= ($urandom_range(0, 99) >= 77);
        MODE_TX_SLOW: out_tready <= ($urandom_range(0, 99) >= 35);
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // One request; valid stays high into the next call when no gap is drawn
  task automatic send_request(input logic cmd, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(cmd, b);
    n_sent++;
  endtask

  task automatic send_frame(input logic [7:0] flags, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] turn,
                            input logic [7:0] sum_skew, input logic [7:0] end_byte);
    logic [7:0] sum;
    sum = flags + x + y + turn + sum_skew;
    send_request(CMD_BYTE, FRAME_START);
    send_request(CMD_BYTE, flags);
    send_request(CMD_BYTE, x);
    send_request(CMD_BYTE, y);
    send_request(CMD_BYTE, turn);
    send_request(CMD_BYTE, sum);
    send_request(CMD_BYTE, end_byte);
  endtask

  // Mostly good frames with random content, else buttons, noise, broken frames or a line error
  task automatic send_random_burst();
    int         pick;
    int         cut;
    logic [7:0] fl, x, y, t, end_b;
    pick = $urandom_range(0, 99);
    fl = 8'($urandom);
    x = 8'($urandom);
    y = 8'($urandom);
    t = 8'($urandom);
    if (pick < 55) begin
      send_frame(fl, x, y, t, 8'd0, FRAME_END);
    end else if (pick < 62) begin
      send_frame(fl, x, y, t, 8'($urandom_range(1, 255)), FRAME_END);
    end else if (pick < 68) begin
      end_b = 8'($urandom);
      if (end_b == FRAME_END) end_b = FRAME_START;
      send_frame(fl, x, y, t, 8'd0, end_b);
    end else if (pick < 74) begin
      // frame cut short by a line error
      cut = $urandom_range(0, 5);
      send_request(CMD_BYTE, FRAME_START);
      repeat (cut) send_request(CMD_BYTE, 8'($urandom));
      send_request(CMD_LINE_ERROR, 8'($urandom));
    end else if (pick < 90) begin
      send_request(CMD_BYTE, BUTTON_CODES[$urandom_range(0, 12)]);
    end else if (pick < 96) begin
      send_request(CMD_BYTE, 8'($urandom));
    end else begin
      send_request(CMD_LINE_ERROR, 8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every button, an unknown byte, an extreme frame with both
    // suction bits, a bad-checksum frame carrying a start byte as payload,
    // a line error inside a frame, then stop-all
    foreach (BUTTON_CODES[i]) send_request(CMD_BYTE, BUTTON_CODES[i]);
    send_request(CMD_BYTE, 8'hFF);
    send_frame(8'hFF, 8'h80, 8'h7F, 8'hFF, 8'd0, FRAME_END);
    send_frame(FRAME_START, 8'h00, 8'h01, 8'h7F, 8'd3, FRAME_END);
    send_request(CMD_BYTE, FRAME_START);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_LINE_ERROR, 8'hFF);
    send_request(CMD_BYTE, STOP_ALL);

    // Random: receiver slow, then sender slow, then no idling after one long hold-off
    while (n_sent < 330) send_random_burst();
    idle_mode <= MODE_TX_SLOW;
    send_idle_pct = 77;
    while (n_sent < 640) send_random_burst();
    idle_mode <= MODE_NO_IDLE;
    send_idle_pct = 0;
    while (n_sent < 950) send_random_burst();
    in_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.outstanding() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $time, board.outstanding());
    end

    $display("Ran %0d requests incl. %0d line errors; %0d frames accepted, %0d refresh pulses",
             board.requests, board.line_errors, board.frames_taken, board.refreshes);
    $display("Back-pressure: slow receiver, slow sender, free running with a long hold-off");
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
